/* sv/vwap_and_ema_indicator_macros.svh */
// ----------------------------------------------------------------------------
// VWAP and EMA indicator assertion macros
// Shared property forms for the port checker, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef VWAP_AND_EMA_INDICATOR_MACROS_SVH
`define VWAP_AND_EMA_INDICATOR_MACROS_SVH

// Same-cycle implication.
`define VWEMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VWEMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/vwema_pkg.sv */
// ----------------------------------------------------------------------------
// VWAP and EMA indicator package
// Field widths, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package vwema_pkg;

  // Field and state widths.
  localparam int PRICE_W   = 24;
  localparam int VOLUME_W  = 24;
  localparam int PERIOD_W  = 16;
  localparam int ALPHA_W   = 17;
  localparam int EMA_W     = 32;
  localparam int VWAP_W    = 24;
  localparam int VOLTOT_W  = 40;
  localparam int PVTOT_W   = 64;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 17;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 1'b1;

  // Tick sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROUND,
    ST_UPDATE,
    ST_FINISH,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

/* sv/vwap_and_ema_indicator.sv */
// ----------------------------------------------------------------------------
// VWAP and EMA indicator
// Per-tick exponential moving average and end-of-series VWAP.
// ----------------------------------------------------------------------------
// Ticks arrive on the in_ stream (price and volume in tdata, tlast marks the
// final tick of a series). Each tick produces exactly one result on the out_
// stream: the EMA in Q24.8 and the VWAP in tdata, valid flags in tuser, and
// tlast copying the input flag. The VWAP is nonzero only on the last tick.
// A tick is processed one at a time. Both serial multipliers start at the
// request; the price x volume product, which also covers the EMA product,
// holds the sequencer in its multiply step. Round, update, finish and output
// steps follow, and the next request is taken once the sequencer is idle
// again. A last tick that needs the VWAP adds a pass through the 24-bit
// serial divider after the finish step.
// in_tready is high only while the sequencer is idle and out of reset.
// A finished result sits in the output register; the next tick is taken
// while it waits, and the sequencer holds in its output step if the
// receiver stalls with a result pending.
// Reset (rst_n low, synchronous) clears period and alpha to zero and clears
// all series state; configuration is written through cfg_. The user must
// write it only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module vwap_and_ema_indicator (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Configuration writes.
  input  wire logic                                cfg_we,
  input  wire logic [vwema_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [vwema_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Tick stream.
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [47:0]                         in_tdata,  // price[23:0], volume[47:24]
  input  wire logic                                in_tlast,
  // Result stream.
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [55:0]                              out_tdata, // ema_value[31:0], vwap[55:32]
  output logic [1:0]                               out_tuser, // ema_valid[0], vwap_valid[1]
  output logic                                     out_tlast
);

  localparam int PW  = vwema_pkg::PRICE_W;
  localparam int VW  = vwema_pkg::VOLUME_W;
  localparam int EW  = vwema_pkg::EMA_W;
  localparam int AW  = vwema_pkg::ALPHA_W;
  localparam int TW  = vwema_pkg::VOLTOT_W;
  localparam int SW  = vwema_pkg::PVTOT_W;
  localparam int QW  = vwema_pkg::VWAP_W;
  localparam int STW = EW + 2;

  vwema_pkg::state_t state_r, state_nxt;

  logic               accept;
  logic               mul_start;
  logic               div_start;
  logic               out_load;

  logic [vwema_pkg::PERIOD_W-1:0] period_r;
  logic [AW-1:0]      alpha_r;

  logic [PW-1:0]      price_r;
  logic [VW-1:0]      vol_r;
  logic               last_r;
  logic               neg_r;
  logic [STW-1:0]     step_r;

  logic [EW-1:0]      avg_r;
  logic               started_r;
  logic [vwema_pkg::PERIOD_W-1:0] ticks_r;
  logic [TW-1:0]      vol_tot_r;
  logic [SW-1:0]      pv_tot_r;

  logic [EW-1:0]      ema_out_r;
  logic               ema_ok_r;
  logic               div_used_r;

  logic               out_valid_r;
  logic [55:0]        out_data_r;
  logic [1:0]         out_user_r;
  logic               out_last_r;

  logic [EW-1:0]      in_price_q;
  logic               in_neg;
  logic [EW-1:0]      in_mag;
  logic [EW-1:0]      price_q;
  logic [EW+AW-1:0]   ema_prod;
  logic [PW+VW-1:0]   pv_prod;
  logic               ema_busy;
  logic               pv_busy;
  logic               div_busy;
  logic [QW-1:0]      div_q;
  logic [EW+AW:0]     rounded;
  logic [EW+1:0]      up_sum;
  logic [EW-1:0]      ema_new;

  // Distance of the new price from the average, taken at the request.
  assign in_price_q = {in_tdata[PW-1:0], 8'h00};
  assign in_neg     = in_price_q < avg_r;
  assign in_mag     = in_neg ? (avg_r - in_price_q) : (in_price_q - avg_r);
  assign price_q    = {price_r, 8'h00};

  vwema_mul #(.WA(EW), .WB(AW)) u_ema_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (in_mag),
    .b     (alpha_r),
    .busy  (ema_busy),
    .prod  (ema_prod)
  );

  vwema_mul #(.WA(PW), .WB(VW)) u_pv_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (in_tdata[PW-1:0]),
    .b     (in_tdata[PW+VW-1:PW]),
    .busy  (pv_busy),
    .prod  (pv_prod)
  );

  vwema_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pv_tot_r),
    .divisor  (vol_tot_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Round the scaled step to nearest, ties away from zero (magnitude form).
  assign rounded = {1'b0, ema_prod} + (EW+AW+1)'(32768);

  // Apply the step with saturation at both ends.
  assign up_sum = {2'b00, avg_r} + step_r;
  always_comb begin
    if (neg_r) begin
      ema_new = (step_r >= {2'b00, avg_r}) ? '0 : (avg_r - step_r[EW-1:0]);
    end else begin
      ema_new = (up_sum[EW+1:EW] != 2'b00) ? {EW{1'b1}} : up_sum[EW-1:0];
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vwema_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and strobes.
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    accept    = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      vwema_pkg::ST_IDLE: begin
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          accept    = 1'b1;
          mul_start = 1'b1;
          state_nxt = vwema_pkg::ST_MUL;
        end
      end
      vwema_pkg::ST_MUL: begin
        if (!ema_busy && !pv_busy) begin
          state_nxt = vwema_pkg::ST_ROUND;
        end
      end
      vwema_pkg::ST_ROUND: begin
        state_nxt = vwema_pkg::ST_UPDATE;
      end
      vwema_pkg::ST_UPDATE: begin
        state_nxt = vwema_pkg::ST_FINISH;
      end
      vwema_pkg::ST_FINISH: begin
        if (last_r && (period_r != '0) && (vol_tot_r != '0)) begin
          div_start = 1'b1;
          state_nxt = vwema_pkg::ST_DIV;
        end else begin
          state_nxt = vwema_pkg::ST_OUT;
        end
      end
      vwema_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_nxt = vwema_pkg::ST_OUT;
        end
      end
      vwema_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = vwema_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vwema_pkg::ST_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      alpha_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vwema_pkg::REG_PERIOD: period_r <= cfg_data[vwema_pkg::PERIOD_W-1:0];
        vwema_pkg::REG_ALPHA:  alpha_r  <= cfg_data[AW-1:0];
        default: ;
      endcase
    end
  end

  // Captured tick and rounded step.
  always_ff @(posedge clk) begin
    if (accept) begin
      price_r <= in_tdata[PW-1:0];
      vol_r   <= in_tdata[PW+VW-1:PW];
      last_r  <= in_tlast;
      neg_r   <= in_neg;
    end
    if (state_r == vwema_pkg::ST_ROUND) begin
      step_r <= rounded[EW+AW:16];
    end
  end

  // Series state: EMA and VWAP sums, cleared after the last tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r      <= '0;
      started_r  <= 1'b0;
      ticks_r    <= '0;
      vol_tot_r  <= '0;
      pv_tot_r   <= '0;
      ema_out_r  <= '0;
      ema_ok_r   <= 1'b0;
      div_used_r <= 1'b0;
    end else if (state_r == vwema_pkg::ST_UPDATE) begin
      if (period_r != '0) begin
        started_r <= 1'b1;
        ema_ok_r  <= 1'b1;
        if (!started_r) begin
          avg_r     <= price_q;
          ema_out_r <= price_q;
        end else begin
          avg_r     <= ema_new;
          ema_out_r <= ema_new;
        end
      end else begin
        ema_out_r <= '0;
        ema_ok_r  <= 1'b0;
      end
      if (ticks_r < period_r) begin
        ticks_r   <= ticks_r + 1'b1;
        vol_tot_r <= vol_tot_r + TW'(vol_r);
        pv_tot_r  <= pv_tot_r + SW'(pv_prod);
      end
    end else if (state_r == vwema_pkg::ST_FINISH) begin
      div_used_r <= div_start;
      if (last_r) begin
        avg_r     <= '0;
        started_r <= 1'b0;
        ticks_r   <= '0;
        vol_tot_r <= '0;
        pv_tot_r  <= '0;
      end
    end
  end

  // Output register, freed when the receiver takes the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {(div_used_r ? div_q : {QW{1'b0}}), ema_out_r};
      out_user_r <= {last_r, ema_ok_r};
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

/* sv/vwema_mul.sv */
// ----------------------------------------------------------------------------
// Serial shift-add multiplier
// Unsigned A x B, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vwema_mul #(
  parameter int WA = 32,
  parameter int WB = 17
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WA-1:0]    a,
  input  wire logic [WB-1:0]    b,
  output logic                  busy,
  output logic [WA+WB-1:0]      prod
);

  localparam int CW = $clog2(WB + 1);

  logic              busy_r;
  logic [CW-1:0]     cnt_r;
  logic [WA-1:0]     a_r;
  logic [WA+WB-1:0]  prod_r;
  logic [WA+WB-1:0]  prod_nxt;
  logic [WA:0]       sum;

  // Upper half plus the multiplicand when the current multiplier bit is set.
  assign sum      = {1'b0, prod_r[WA+WB-1:WB]} + (prod_r[0] ? {1'b0, a_r} : '0);
  assign prod_nxt = {sum, prod_r[WB-1:1]};

  // Step counter and busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == CW'(WB - 1)) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Product register: low half starts as the multiplier and shifts out.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a;
      prod_r <= {{WA{1'b0}}, b};
    end else if (busy_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign busy = busy_r;
  assign prod = prod_r;

endmodule

`default_nettype wire

/* sv/vwema_div.sv */
// ----------------------------------------------------------------------------
// Serial restoring divider
// Price-volume total over volume total, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vwema_div (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [vwema_pkg::PVTOT_W-1:0]   dividend,
  input  wire logic [vwema_pkg::VOLTOT_W-1:0]  divisor,
  output logic                                 busy,
  output logic [vwema_pkg::VWAP_W-1:0]         quotient
);

  localparam int QW = vwema_pkg::VWAP_W;
  localparam int RW = vwema_pkg::VOLTOT_W;
  localparam int CW = $clog2(QW + 1);

  logic           busy_r;
  logic [CW-1:0]  cnt_r;
  logic [RW-1:0]  rem_r;
  logic [RW-1:0]  rem_nxt;
  logic [QW-1:0]  q_r;
  logic [QW-1:0]  q_nxt;
  logic [RW-1:0]  dvs_r;
  logic [RW+1:0]  diff;

  // The quotient is known to fit in QW bits, so the upper dividend bits
  // already form a partial remainder below the divisor.
  assign diff    = {1'b0, rem_r, q_r[QW-1]} - {2'b00, dvs_r};
  assign rem_nxt = diff[RW+1] ? {rem_r[RW-2:0], q_r[QW-1]} : diff[RW-1:0];
  assign q_nxt   = {q_r[QW-2:0], ~diff[RW+1]};

  // Step counter and busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == CW'(QW - 1)) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[vwema_pkg::PVTOT_W-1:QW];
      q_r   <= dividend[QW-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

/* sv/vwema_checker.sv */
// ----------------------------------------------------------------------------
// VWAP and EMA indicator port checker
// Watches the top-level ports and checks result consistency over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vwap_and_ema_indicator_macros.svh"

module vwema_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  // A stalled result keeps its payload.
  `VWEMA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // The VWAP flag follows the end-of-series marker.
  `VWEMA_ASSERT_NOW(a_vwap_flag, out_tvalid, out_tuser[1] == out_tlast, "vwap_valid differs from tlast")

  // A disabled EMA reports zero.
  `VWEMA_ASSERT_NOW(a_ema_zero, out_tvalid && !out_tuser[0], out_tdata[31:0] == 32'd0, "invalid EMA not zero")

  // The VWAP field is zero except on the last tick.
  `VWEMA_ASSERT_NOW(a_vwap_zero, out_tvalid && !out_tlast, out_tdata[55:32] == 24'd0, "VWAP set before last tick")

  // One tick at a time: no request is taken right after another.
  `VWEMA_ASSERT_NEXT(a_one_tick, in_tvalid && in_tready, !in_tready, "request taken while busy")

endmodule

bind vwap_and_ema_indicator vwema_checker u_vwema_checker (.*);

`default_nettype wire
